// ===== hw/rtl/positional_list_insert_delete_assert.svh =====
// Assertion macros for the positional list insert/delete block
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// check b in the cycle after a
`define PLID_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: %m");

// check b in the same cycle as a
`define PLID_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: %m");

`endif

// ===== hw/rtl/plid_pkg.sv =====
// Package: types and constants of the positional list insert/delete block
package plid_pkg;
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int LEN_W    = 7;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	typedef struct packed {
		logic                     action;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] removed_value;
		logic [LEN_W-1:0]         length;
	} out_item_t;

	typedef struct packed {
		logic              ins;
		logic              del;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;
endpackage

// ===== hw/rtl/plid_cell.sv =====
// One storage cell of the shifting element row
module plid_cell import plid_pkg::*; (
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] sel_data
);
	logic [DATA_W-1:0] data_q;
	logic [CMP_W-1:0]  idx_x;
	logic [CMP_W-1:0]  pos_x;

	assign idx_x = CMP_W'(idx);
	assign pos_x = CMP_W'(ctl.pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx_x == pos_x) begin
				data_q <= ctl.value;
			end else if (idx_x > pos_x) begin
				data_q <= left;
			end
		end else if (ctl.del) begin
			if (idx_x >= pos_x) begin
				data_q <= right;
			end
		end
	end

	assign data     = data_q;
	assign sel_data = (idx_x == pos_x) ? data_q : '0;
endmodule

// ===== hw/rtl/positional_list_insert_delete.sv =====
// Top level: positional list store with insert and delete by index
// Every accepted item gives one result, shown with done for one cycle in the
// cycle after start was taken. busy never rises, so an item can be started in
// every cycle. A row of CAPACITY cells shifts all elements at or past the
// position by one place as the item is taken; length is the element count
// after the item, low 7 bits. The receiver cannot hold results off: take
// result in the cycle in which done is high.
module positional_list_insert_delete import plid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result
);
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	out_item_t         result_q;
	logic              acc;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  cnt_x;
	logic              ins_bad;
	logic              full;
	logic              del_bad;
	cell_ctl_t         ctl;
	logic [CNT_W-1:0]  cnt_next;
	logic [1:0]        status;
	logic [DATA_W-1:0] removed;
	logic [DATA_W-1:0] data  [CAPACITY];
	logic [DATA_W-1:0] sel   [CAPACITY];
	logic [DATA_W-1:0] left  [CAPACITY];
	logic [DATA_W-1:0] right [CAPACITY];

	assign busy  = 1'b0;
	assign acc   = start && !busy;
	assign pos_x = CMP_W'(item.position);
	assign cnt_x = CMP_W'(cnt_q);

	assign ins_bad = pos_x > cnt_x;
	assign full    = cnt_q == CNT_W'(CAPACITY);
	assign del_bad = pos_x >= cnt_x;

	always_comb begin
		ctl.ins   = acc && (item.action == ACT_INSERT) && !ins_bad && !full;
		ctl.del   = acc && (item.action == ACT_DELETE) && !del_bad;
		ctl.pos   = item.position;
		ctl.value = item.value;
	end

	always_comb begin
		status   = ST_DONE;
		cnt_next = cnt_q;
		if (item.action == ACT_INSERT) begin
			if (ins_bad) begin
				status = ST_RANGE;
			end else if (full) begin
				status = ST_FULL;
			end else begin
				cnt_next = cnt_q + CNT_W'(1);
			end
		end else begin
			if (del_bad) begin
				status = ST_RANGE;
			end else begin
				cnt_next = cnt_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		left[0]              = '0;
		right[CAPACITY-1]    = '0;
		for (int i = 1; i < CAPACITY; i++) begin
			left[i]      = data[i-1];
			right[i-1]   = data[i];
		end
	end

	always_comb begin
		removed = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed = removed | sel[i];
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		plid_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(g)),
			.ctl      (ctl),
			.left     (left[g]),
			.right    (right[g]),
			.data     (data[g]),
			.sel_data (sel[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= acc;
			if (acc) begin
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			result_q.status        <= status;
			result_q.removed_value <= ctl.del ? removed : '0;
			result_q.length        <= LEN_W'(cnt_next);
		end
	end

	assign done   = done_q;
	assign result = result_q;
endmodule

// ===== hw/rtl/plid_checker.sv =====
// Port checker for the positional list insert/delete block, with its bind
`include "positional_list_insert_delete_assert.svh"

module plid_checker import plid_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  item,
	input logic      done,
	input out_item_t result
);
	`PLID_ASSERT_NEXT(a_done_after_start, clk, arst_n, start && !busy, done)
	`PLID_ASSERT_NEXT(a_no_spurious_done, clk, arst_n, !(start && !busy), !done)
	`PLID_ASSERT_SAME(a_reject_keeps_len, clk, arst_n, done && $past(done) && result.status != ST_DONE, result.length == $past(result.length))
	`PLID_ASSERT_SAME(a_reject_no_value, clk, arst_n, done && result.status != ST_DONE, result.removed_value == '0)
endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (.*);
